// ===== rtl/flash_doubleword_write_combiner_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the flash double-word write combiner
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef FLASH_DOUBLEWORD_WRITE_COMBINER_TOP_ASSERT_SVH
`define FLASH_DOUBLEWORD_WRITE_COMBINER_TOP_ASSERT_SVH

// same-cycle implication
`define FDWC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fdwc: same-cycle check failed");

// next-cycle implication
`define FDWC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fdwc: next-cycle check failed");

`endif

// ===== rtl/fdwc_pkg.sv =====
// ---------------------------------------------------------------------------
// fdwc_pkg
// Types and constants of the flash double-word write combiner.
// ---------------------------------------------------------------------------
package fdwc_pkg;

    localparam int ADDRESS_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH       = 2;
    localparam int BYTES_PER_WORD    = 8;
    localparam int INDEX_WIDTH       = 29;

    localparam logic [7:0] ALL_LANES = 8'hFF;

    // request codes
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_FLUSH   = 2'd1;
    localparam logic [1:0] REQ_DISCARD = 2'd2;

    // result status codes
    localparam logic [1:0] ST_PROGRAM = 2'd0;
    localparam logic [1:0] ST_SKIP    = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] wr_addr;
        logic [7:0]  byte_data;
        logic        chunk_end;
        logic [63:0] flash_word;
    } t_in;

    typedef struct packed {
        logic [INDEX_WIDTH-1:0] word_index;
        logic [63:0]            word_value;
        logic [1:0]             status;
    } t_out;

    // word handed from front to back
    typedef struct packed {
        logic [INDEX_WIDTH-1:0] index;
        logic [63:0]            value;
        logic [63:0]            flash;
    } t_issue;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

endpackage

// ===== rtl/fdwc_front.sv =====
// ---------------------------------------------------------------------------
// fdwc_front
// Accepts requests, merges bytes into the pending word, issues finished words.
// ---------------------------------------------------------------------------
module fdwc_front #(
    parameter int ADDRESS_WIDTH = fdwc_pkg::ADDRESS_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  fdwc_pkg::t_in    i_in_data,
    input  fdwc_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output fdwc_pkg::t_issue o_push_data
);

    localparam logic [32:0] AddrMaskW = (33'd1 << ADDRESS_WIDTH) - 33'd1;
    localparam logic [31:0] AddrMask  = AddrMaskW[31:0];
    localparam int          IW        = fdwc_pkg::INDEX_WIDTH;

    logic          r_pend_valid;
    logic [IW-1:0] r_pend_index;
    logic [63:0]   r_pend_value;
    logic [7:0]    r_pend_mask;
    logic [63:0]   r_pend_flash;

    logic          n_pend_valid;
    logic [IW-1:0] n_pend_index;
    logic [63:0]   n_pend_value;
    logic [7:0]    n_pend_mask;
    logic [63:0]   n_pend_flash;

    logic          accept;
    logic [31:0]   addr;
    logic [IW-1:0] idx;
    logic [2:0]    lane;
    logic          same_word;
    logic [63:0]   base_value;
    logic [63:0]   base_flash;
    logic [7:0]    base_mask;
    logic [63:0]   merged;
    logic [7:0]    merged_mask;

    assign o_in_stall = i_q_stat.full;
    assign accept     = i_in_valid && !i_q_stat.full;

    assign addr      = i_in_data.wr_addr & AddrMask;
    assign idx       = addr[31:3];
    assign lane      = addr[2:0];
    assign same_word = r_pend_valid && (r_pend_index == idx);

    // open from flash contents unless the byte lands in the pending word
    assign base_value = same_word ? r_pend_value : i_in_data.flash_word;
    assign base_flash = same_word ? r_pend_flash : i_in_data.flash_word;
    assign base_mask  = same_word ? r_pend_mask  : 8'h00;

    always_comb begin
        for (int b = 0; b < fdwc_pkg::BYTES_PER_WORD; b++) begin
            merged[b*8 +: 8] = (lane == 3'(b)) ? i_in_data.byte_data : base_value[b*8 +: 8];
            merged_mask[b]   = (lane == 3'(b)) ? 1'b1 : base_mask[b];
        end
    end

    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend_index = r_pend_index;
        n_pend_value = r_pend_value;
        n_pend_mask  = r_pend_mask;
        n_pend_flash = r_pend_flash;
        o_push       = 1'b0;
        o_push_data  = '{index: r_pend_index, value: r_pend_value, flash: r_pend_flash};
        if (accept) begin
            unique case (i_in_data.req_type)
                fdwc_pkg::REQ_FLUSH: begin
                    o_push       = r_pend_valid;
                    n_pend_valid = 1'b0;
                end
                fdwc_pkg::REQ_DISCARD: begin
                    n_pend_valid = 1'b0;
                end
                fdwc_pkg::REQ_WRITE: begin
                    n_pend_valid = 1'b1;
                    n_pend_index = idx;
                    n_pend_value = merged;
                    n_pend_mask  = merged_mask;
                    n_pend_flash = base_flash;
                    if (r_pend_valid && !same_word) begin
                        // issue the old word, keep the new one open
                        o_push = 1'b1;
                    end else if (i_in_data.chunk_end && merged_mask == fdwc_pkg::ALL_LANES) begin
                        o_push       = 1'b1;
                        o_push_data  = '{index: idx, value: merged, flash: base_flash};
                        n_pend_valid = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else begin
            r_pend_valid <= n_pend_valid;
        end
        r_pend_index <= n_pend_index;
        r_pend_value <= n_pend_value;
        r_pend_mask  <= n_pend_mask;
        r_pend_flash <= n_pend_flash;
    end

endmodule

// ===== rtl/fdwc_queue.sv =====
// ---------------------------------------------------------------------------
// fdwc_queue
// Short FIFO of issued words between front and back.
// ---------------------------------------------------------------------------
`include "flash_doubleword_write_combiner_top_assert.svh"

module fdwc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fdwc_pkg::t_issue  i_push_data,
    input  logic              i_pop,
    output fdwc_pkg::t_issue  o_head,
    output fdwc_pkg::t_q_stat o_stat
);

    localparam int Depth = fdwc_pkg::QUEUE_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    fdwc_pkg::t_issue r_mem [Depth];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CntW'(Depth));
    assign o_stat.valid = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + PtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

    `FDWC_ASSERT_NOW(a_no_overflow, i_push, !o_stat.full)
    `FDWC_ASSERT_NOW(a_no_underflow, i_pop, o_stat.valid)
    `FDWC_ASSERT_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + CntW'(1))

endmodule

// ===== rtl/fdwc_back.sv =====
// ---------------------------------------------------------------------------
// fdwc_back
// Compares issued words with flash and drives the result register.
// ---------------------------------------------------------------------------
module fdwc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fdwc_pkg::t_q_stat i_q_stat,
    input  fdwc_pkg::t_issue  i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output fdwc_pkg::t_out    o_out_data
);

    logic           r_out_valid;
    fdwc_pkg::t_out r_out_data;
    logic [1:0]     status;

    assign o_pop = i_q_stat.valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        if (i_head.value == i_head.flash) begin
            status = fdwc_pkg::ST_SKIP;
        end else if ((i_head.flash & i_head.value) != i_head.value) begin
            status = fdwc_pkg::ST_ERROR;
        end else begin
            status = fdwc_pkg::ST_PROGRAM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid <= i_q_stat.valid;
        end
        if (o_pop) begin
            r_out_data <= '{word_index: i_head.index, word_value: i_head.value, status: status};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/flash_doubleword_write_combiner_top.sv =====
// ---------------------------------------------------------------------------
// flash_doubleword_write_combiner_top
// Merges a byte stream into 64-bit flash program words with status.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one request per
//   transaction: write one byte, flush the pending word, or discard it on an
//   erase. Each write carries the current flash contents of its double-word.
//   Output channel (o_out_valid / i_out_stall / o_out_data) returns at most
//   one result per request: the double-word index, the merged value and a
//   status of program, unchanged (skip) or invalid 0-to-1 change (error).
//   Throughput: one request per cycle while the queue is not full, set by the
//   combinational byte merge in the front end. A result is registered on its
//   way to the output, first by the queue write, then by the result register
//   load.
//   A stalled receiver holds the result register; the two-entry queue keeps
//   taking words until it fills, then o_in_stall rises. Requests causing no
//   result pass through even when the output is stalled, while queue room
//   remains.
//   Reset (i_rst_n low, synchronous) drops the pending word, empties the
//   queue and clears the output valid.
// ---------------------------------------------------------------------------
module flash_doubleword_write_combiner_top #(
    parameter int ADDRESS_WIDTH = fdwc_pkg::ADDRESS_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  fdwc_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output fdwc_pkg::t_out o_out_data
);

    fdwc_pkg::t_q_stat q_stat;
    fdwc_pkg::t_issue  push_data;
    fdwc_pkg::t_issue  head;
    logic              push;
    logic              pop;

    // front end: request decode and byte merge
    fdwc_front #(
        .ADDRESS_WIDTH(ADDRESS_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // decouple merge from result delivery
    fdwc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_stat      (q_stat)
    );

    // back end: flash compare and result register
    fdwc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
